>>> design/cisot_pkg.sv
// Shared types and constants of the compressed-ISO sector index translator.
// No dependencies; used by cisot_ctrl, cisot_dp and the top level.
`timescale 1ns / 1ps

package cisot_pkg;

  localparam int DEF_SECTOR_BYTES = 2048;
  localparam int DEF_WINDOW_WORDS = 128;
  localparam logic [31:0] HEADER_BYTES = 32'd24;

  // input operation codes
  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_WORD = 2'd1;
  localparam logic [1:0] OP_FILL = 2'd2;

  // result action codes
  localparam logic [2:0] ACT_FETCH  = 3'd0;
  localparam logic [2:0] ACT_RAW    = 3'd1;
  localparam logic [2:0] ACT_FILL   = 3'd2;
  localparam logic [2:0] ACT_DECOMP = 3'd3;
  localparam logic [2:0] ACT_ERROR  = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FIRST  = 2'd1;
  localparam logic [1:0] ERR_SECOND = 2'd2;
  localparam logic [1:0] ERR_FILL   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SHIFT = 2'd1;
  localparam logic [1:0] REG_CODEC = 2'd2;

  // index window read address select
  typedef enum logic [1:0] {
    RS_SECTOR,
    RS_NEXT,
    RS_ZERO
  } rsel_t;

  // result kinds built by the datapath
  typedef enum logic [3:0] {
    EM_RAW_SECTOR,
    EM_RAW_BLOCK,
    EM_FETCH_CUR,
    EM_FETCH_NEXT,
    EM_FILL,
    EM_DECOMP,
    EM_DECOMP_NEW,
    EM_ERR_FIRST,
    EM_ERR_SECOND,
    EM_ERR_FILL
  } em_t;

  typedef struct packed {
    logic  latch;
    logic  rd_en;
    rsel_t rd_sel;
    logic  pend_ld;
    logic  word_wr;
    logic  fpos_clr;
    logic  win_set;
    logic  win_clr;
    logic  win_second;
    logic  blk_ld;
    logic  size_ld;
    logic  span_set;
    logic  span_clr;
    logic  emit;
    em_t   em;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       last;
    logic       ok;
    logic       mode;
    logic       hit_cur;
    logic       hit_next;
    logic       raw_entry;
    logic       refill;
    logic       out_free;
  } sts_t;

endpackage

>>> design/cisot_ctrl.sv
// Controller state machine of the sector index translator.
// Depends on cisot_pkg; drives cisot_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module cisot_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  cisot_pkg::sts_t sts,
  output cisot_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WFIRST,
    S_WSECOND,
    S_WFILL,
    S_DIDLE,
    S_DFIRST,
    S_DSECOND,
    S_DFILL,
    S_Z1,
    S_Z2,
    S_E1,
    S_E2,
    S_TEST
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = cisot_pkg::RS_SECTOR;
    cmd.em     = cisot_pkg::EM_RAW_SECTOR;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE, S_WFIRST, S_WSECOND, S_WFILL: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
        if (in_tvalid) begin
          unique case (state_r)
            S_IDLE:    state_nxt = S_DIDLE;
            S_WFIRST:  state_nxt = S_DFIRST;
            S_WSECOND: state_nxt = S_DSECOND;
            default:   state_nxt = S_DFILL;
          endcase
        end
      end
      S_DIDLE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
          if (sts.op == cisot_pkg::OP_READ) begin
            cmd.pend_ld = 1'b1;
            if (!sts.mode) begin
              cmd.emit = 1'b1;
              cmd.em   = cisot_pkg::EM_RAW_SECTOR;
            end else if (sts.hit_cur) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = cisot_pkg::RS_SECTOR;
              state_nxt  = S_E1;
            end else begin
              cmd.emit     = 1'b1;
              cmd.em       = cisot_pkg::EM_FETCH_CUR;
              cmd.fpos_clr = 1'b1;
              state_nxt    = S_WFIRST;
            end
          end
        end
      end
      S_DFIRST, S_DSECOND: begin
        if (sts.out_free) begin
          state_nxt = (state_r == S_DFIRST) ? S_WFIRST : S_WSECOND;
          if (sts.op == cisot_pkg::OP_WORD) begin
            cmd.word_wr = 1'b1;
            if (sts.last) begin
              if (!sts.ok) begin
                cmd.win_clr = 1'b1;
                cmd.emit    = 1'b1;
                cmd.em      = (state_r == S_DFIRST) ? cisot_pkg::EM_ERR_FIRST
                                                    : cisot_pkg::EM_ERR_SECOND;
                state_nxt   = S_IDLE;
              end else begin
                cmd.win_set    = 1'b1;
                cmd.win_second = (state_r == S_DSECOND);
                state_nxt      = (state_r == S_DFIRST) ? S_Z1 : S_Z2;
              end
            end
          end
        end
      end
      S_DFILL: begin
        if (sts.out_free) begin
          state_nxt = S_WFILL;
          if (sts.op == cisot_pkg::OP_FILL) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
            if (!sts.ok) begin
              cmd.span_clr = 1'b1;
              cmd.em       = cisot_pkg::EM_ERR_FILL;
            end else begin
              cmd.span_set = 1'b1;
              cmd.em       = cisot_pkg::EM_DECOMP_NEW;
            end
          end
        end
      end
      S_Z1, S_Z2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cisot_pkg::RS_ZERO;
        state_nxt  = (state_r == S_Z1) ? S_E1 : S_E2;
      end
      S_E1: begin
        if (sts.out_free) begin
          cmd.blk_ld = 1'b1;
          if (sts.raw_entry) begin
            cmd.emit  = 1'b1;
            cmd.em    = cisot_pkg::EM_RAW_BLOCK;
            state_nxt = S_IDLE;
          end else if (sts.hit_next) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = cisot_pkg::RS_NEXT;
            state_nxt  = S_E2;
          end else begin
            cmd.emit     = 1'b1;
            cmd.em       = cisot_pkg::EM_FETCH_NEXT;
            cmd.fpos_clr = 1'b1;
            state_nxt    = S_WSECOND;
          end
        end
      end
      S_E2: begin
        cmd.size_ld = 1'b1;
        state_nxt   = S_TEST;
      end
      S_TEST: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.refill) begin
            cmd.em    = cisot_pkg::EM_FILL;
            state_nxt = S_WFILL;
          end else begin
            cmd.em    = cisot_pkg::EM_DECOMP;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/cisot_dp.sv
// Datapath of the sector index translator: index window memory, span and
// window tracking, size arithmetic, result register. Depends on cisot_pkg.
`timescale 1ns / 1ps

module cisot_dp #(
  parameter int SECTOR_BYTES = cisot_pkg::DEF_SECTOR_BYTES,
  parameter int WINDOW_WORDS = cisot_pkg::DEF_WINDOW_WORDS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [79:0]     in_tdata,
  input  logic [1:0]      in_tuser,
  input  logic            in_tlast,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [71:0]     out_tdata,
  output logic [2:0]      out_tuser,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [3:0]      cfg_data,
  input  cisot_pkg::cmd_t cmd,
  output cisot_pkg::sts_t sts
);

  localparam int AW = $clog2(WINDOW_WORDS);
  localparam int FW = $clog2(WINDOW_WORDS + 1);
  localparam logic [31:0] SB32 = 32'(SECTOR_BYTES);
  localparam logic [15:0] SB16 = 16'(SECTOR_BYTES);
  localparam logic [15:0] FETCH_BYTES = 16'(WINDOW_WORDS * 4);

  logic        mode_r, codec_r;
  logic [3:0]  shift_r;

  logic [1:0]  op_r;
  logic [23:0] sector_r;
  logic [31:0] word_r;
  logic        last_r, ok_r;
  logic [15:0] fbytes_r;

  logic [31:0] mem [WINDOW_WORDS];
  logic [31:0] rdata_r;

  logic [23:0] win_base_r, pend_r;
  logic        win_valid_r, span_valid_r;
  logic [31:0] span_start_r, block_start_r;
  logic [15:0] span_len_r;
  logic [FW-1:0] fpos_r;
  logic [32:0] size_r;

  logic        out_valid_r;
  logic [2:0]  out_act_r;
  logic [31:0] out_addr_r;
  logic [15:0] out_cnt_r, out_boff_r;
  logic        out_codec_r;
  logic [1:0]  out_err_r;

  logic [23:0] next_sector, d_cur, d_next;
  logic [AW-1:0] rd_addr;
  logic [31:0] entry_off;
  logic [33:0] size_u, addend;
  logic [32:0] size_nxt;
  logic        fpos_room;

  logic [2:0]  e_act;
  logic [31:0] e_addr;
  logic [15:0] e_cnt, e_boff;
  logic        e_codec;
  logic [1:0]  e_err;

  assign cfg_ready   = 1'b1;
  assign next_sector = pend_r + 24'd1;
  assign d_cur       = sector_r - win_base_r;
  assign d_next      = next_sector - win_base_r;
  assign entry_off   = {1'b0, rdata_r[30:0]} << shift_r;
  assign fpos_room   = (fpos_r < FW'(WINDOW_WORDS));

  always_comb begin
    unique case (cmd.rd_sel)
      cisot_pkg::RS_SECTOR: rd_addr = d_cur[AW-1:0];
      cisot_pkg::RS_NEXT:   rd_addr = d_next[AW-1:0];
      default:              rd_addr = '0;
    endcase
  end

  // compressed size from the following entry, floored at one sector
  always_comb begin
    addend   = (shift_r != 4'd0) ? (34'd1 << shift_r) : 34'd0;
    size_u   = {2'b00, entry_off} - {2'b00, block_start_r} + addend;
    size_nxt = ($signed(size_u) <= $signed(34'(SECTOR_BYTES))) ? 33'(SECTOR_BYTES)
                                                               : size_u[32:0];
  end

  always_comb begin
    sts.op        = op_r;
    sts.last      = last_r;
    sts.ok        = ok_r;
    sts.mode      = mode_r;
    sts.hit_cur   = win_valid_r && (d_cur < 24'(WINDOW_WORDS));
    sts.hit_next  = win_valid_r && (d_next < 24'(WINDOW_WORDS));
    sts.raw_entry = rdata_r[31];
    sts.refill    = !span_valid_r || (block_start_r < span_start_r) ||
                    (({2'b00, block_start_r} + {1'b0, size_r}) >=
                     ({2'b00, span_start_r} + {18'd0, span_len_r}));
    sts.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    e_act   = cisot_pkg::ACT_FETCH;
    e_addr  = '0;
    e_cnt   = '0;
    e_boff  = '0;
    e_codec = 1'b0;
    e_err   = cisot_pkg::ERR_NONE;
    unique case (cmd.em)
      cisot_pkg::EM_RAW_SECTOR: begin
        e_act  = cisot_pkg::ACT_RAW;
        e_addr = {8'd0, sector_r} * SB32;
        e_cnt  = SB16;
      end
      cisot_pkg::EM_RAW_BLOCK: begin
        e_act  = cisot_pkg::ACT_RAW;
        e_addr = entry_off;
        e_cnt  = SB16;
      end
      cisot_pkg::EM_FETCH_CUR: begin
        e_addr = {6'd0, sector_r, 2'b00} + cisot_pkg::HEADER_BYTES;
        e_cnt  = FETCH_BYTES;
      end
      cisot_pkg::EM_FETCH_NEXT: begin
        e_addr = {6'd0, next_sector, 2'b00} + cisot_pkg::HEADER_BYTES;
        e_cnt  = FETCH_BYTES;
      end
      cisot_pkg::EM_FILL: begin
        e_act  = cisot_pkg::ACT_FILL;
        e_addr = block_start_r;
        e_cnt  = (size_r > 33'd65535) ? 16'hFFFF : size_r[15:0];
      end
      cisot_pkg::EM_DECOMP: begin
        e_act   = cisot_pkg::ACT_DECOMP;
        e_addr  = block_start_r;
        e_boff  = 16'(block_start_r - span_start_r);
        e_codec = codec_r;
      end
      cisot_pkg::EM_DECOMP_NEW: begin
        e_act   = cisot_pkg::ACT_DECOMP;
        e_addr  = block_start_r;
        e_codec = codec_r;
      end
      cisot_pkg::EM_ERR_FIRST: begin
        e_act = cisot_pkg::ACT_ERROR;
        e_err = cisot_pkg::ERR_FIRST;
      end
      cisot_pkg::EM_ERR_SECOND: begin
        e_act = cisot_pkg::ACT_ERROR;
        e_err = cisot_pkg::ERR_SECOND;
      end
      cisot_pkg::EM_ERR_FILL: begin
        e_act = cisot_pkg::ACT_ERROR;
        e_err = cisot_pkg::ERR_FILL;
      end
      default: e_act = cisot_pkg::ACT_FETCH;
    endcase
  end

  // index window
  always_ff @(posedge clk) begin
    if (cmd.word_wr && fpos_room) begin
      mem[fpos_r[AW-1:0]] <= word_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // item latch and payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= in_tuser;
      sector_r <= in_tdata[23:0];
      word_r   <= in_tdata[55:24];
      ok_r     <= in_tdata[56];
      fbytes_r <= in_tdata[72:57];
      last_r   <= in_tlast;
    end
    if (cmd.size_ld) begin
      size_r <= size_nxt;
    end
    if (cmd.emit) begin
      out_act_r   <= e_act;
      out_addr_r  <= e_addr;
      out_cnt_r   <= e_cnt;
      out_boff_r  <= e_boff;
      out_codec_r <= e_codec;
      out_err_r   <= e_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= 1'b0;
      shift_r       <= '0;
      codec_r       <= 1'b0;
      win_base_r    <= '0;
      win_valid_r   <= 1'b0;
      span_start_r  <= '0;
      span_len_r    <= '0;
      span_valid_r  <= 1'b0;
      pend_r        <= '0;
      block_start_r <= '0;
      fpos_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          cisot_pkg::REG_MODE:  mode_r  <= cfg_data[0];
          cisot_pkg::REG_SHIFT: shift_r <= cfg_data;
          cisot_pkg::REG_CODEC: codec_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.pend_ld) pend_r <= sector_r;
      if (cmd.fpos_clr) begin
        fpos_r <= '0;
      end else if (cmd.word_wr && fpos_room) begin
        fpos_r <= fpos_r + FW'(1);
      end
      if (cmd.win_clr) win_valid_r <= 1'b0;
      if (cmd.win_set) begin
        win_valid_r <= 1'b1;
        win_base_r  <= cmd.win_second ? next_sector : pend_r;
      end
      if (cmd.blk_ld) block_start_r <= entry_off;
      if (cmd.span_clr) span_valid_r <= 1'b0;
      if (cmd.span_set) begin
        span_valid_r <= 1'b1;
        span_start_r <= block_start_r;
        span_len_r   <= fbytes_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tdata  = {5'd0, out_err_r, out_codec_r, out_boff_r, out_cnt_r, out_addr_r};

endmodule

>>> design/ciso_sector_index_translator_top.sv
// Top level of the compressed-ISO sector index translator.
// Depends on cisot_pkg, cisot_ctrl and cisot_dp.
`timescale 1ns / 1ps

// Turns sector read requests, delivered index words and fill-done reports
// into fetch, raw read, fill and decompress commands, or an error. Every
// input transfer is taken into an item register and decoded from it in a
// decode step that waits for a free result register; no new item is taken
// until the current one is finished. A read request that hits the index
// window, and the last word of an index fetch, take up to two registered reads
// of the index window memory (block entry and following entry), which has one
// write port and one read port, then a size arithmetic step and a refill test.
// The result register frees the input side while a command waits on the
// output; every decode of an input item and every step that can issue a
// command waits while the result register holds a command that has not been
// taken, whether or not it issues one. Configuration writes are accepted every cycle.

module ciso_sector_index_translator_top #(
  parameter int SECTOR_BYTES = cisot_pkg::DEF_SECTOR_BYTES,
  parameter int WINDOW_WORDS = cisot_pkg::DEF_WINDOW_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // sector[23:0], index_word[55:24], fetch_ok[56],
                                  // fill_bytes[72:57], zero[79:73]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  input  logic        in_tlast,   // word_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // byte_address[31:0], byte_count[47:32],
                                  // buffer_offset[63:48], codec_used[64],
                                  // error_code[66:65], zero[71:67]
  output logic [2:0]  out_tuser,  // action[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  cisot_pkg::cmd_t cmd;
  cisot_pkg::sts_t sts;

  cisot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cisot_dp #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .WINDOW_WORDS (WINDOW_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
